>>> hdl/osdmp_pkg.sv
// Shared types, constants and helper functions for the on-screen-display overlay block.
package osdmp_pkg;

    localparam int COORD_BITS     = 12;
    localparam int SLOT_BITS      = 3;
    localparam int COLOR_BITS     = 4;
    localparam int CNT_BITS       = 6;
    localparam int REG_IDX_BITS   = 3;
    localparam int ADDR_BITS      = 5;
    localparam int APB_DATA_BITS  = 32;
    localparam int S_DATA_BITS    = ((SLOT_BITS + 2 * COORD_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS    = ((COLOR_BITS + 7) / 8) * 8;

    localparam int MAX_POINTS_DEF = 8;
    localparam int MARKER_W_DEF   = 16;
    localparam int MARKER_H_DEF   = 16;
    localparam int POINT_W_DEF    = 8;
    localparam int POINT_H_DEF    = 8;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS:0]   span_t;
    typedef logic [COLOR_BITS-1:0] color_t;
    typedef logic [SLOT_BITS-1:0]  slot_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;

    localparam color_t COLOR_RED   = 4'd1;
    localparam color_t COLOR_GREEN = 4'd2;
    localparam color_t COLOR_WHITE = 4'd7;
    localparam color_t COLOR_CLEAR = 4'd15;

    localparam coord_t CANVAS_W_RESET = 12'd1920;
    localparam coord_t CANVAS_H_RESET = 12'd1080;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_CANVAS_W    = 3'd0,
        REG_CANVAS_H    = 3'd1,
        REG_MARKER_X    = 3'd2,
        REG_MARKER_Y    = 3'd3,
        REG_MARKER_COL  = 3'd4,
        REG_POINT_COUNT = 3'd5
    } reg_idx_t;

    // One word travelling down the chain.
    typedef struct packed {
        logic   req;
        slot_t  slot;
        coord_t x;
        coord_t y;
        logic   mhit;
        color_t color;
    } item_t;

    // Settings derived from the registers, seen by every stage.
    typedef struct packed {
        coord_t canvas_w;
        coord_t canvas_h;
        coord_t mk_org_x;
        coord_t mk_org_y;
        color_t mk_color;
        coord_t pt_lim_x;
        coord_t pt_lim_y;
        cnt_t   n_active;
    } view_t;

    function automatic color_t fix_color(color_t c);
        if (c inside {COLOR_RED, COLOR_GREEN, COLOR_WHITE, COLOR_CLEAR})
            return c;
        return COLOR_RED;
    endfunction

    // Largest origin that keeps a rectangle of the given size on the canvas.
    function automatic coord_t place_lim(coord_t span, span_t size);
        span_t d;
        d = {1'b0, span} - size;
        if ({1'b0, span} > size)
            return d[COORD_BITS-1:0];
        return '0;
    endfunction

    function automatic coord_t clamp(coord_t org, coord_t lim);
        return (org > lim) ? lim : org;
    endfunction

    function automatic logic covers(coord_t q, coord_t o, span_t size, coord_t span);
        coord_t d;
        d = q - o;
        return (q < span) && (q >= o) && ({1'b0, d} < size);
    endfunction

endpackage

>>> hdl/osdmp_head.sv
// Entry stage: registers the accepted word and tests it against the marker rectangle.
module osdmp_head #(
    parameter int MARKER_W = osdmp_pkg::MARKER_W_DEF,
    parameter int MARKER_H = osdmp_pkg::MARKER_H_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  osdmp_pkg::item_t   in_item,
    input  osdmp_pkg::view_t   view,
    output logic               out_valid,
    output osdmp_pkg::item_t   out_item
);

    logic             valid_reg;
    osdmp_pkg::item_t item_reg;
    logic             mhit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= in_item;
        end
    end

    always_comb
    begin
        mhit = osdmp_pkg::covers(item_reg.x, view.mk_org_x,
                                 osdmp_pkg::span_t'(MARKER_W), view.canvas_w)
            && osdmp_pkg::covers(item_reg.y, view.mk_org_y,
                                 osdmp_pkg::span_t'(MARKER_H), view.canvas_h);
        out_item       = item_reg;
        out_item.mhit  = mhit;
        out_item.color = mhit ? view.mk_color : osdmp_pkg::COLOR_CLEAR;
    end

    assign out_valid = valid_reg;

endmodule

>>> hdl/osdmp_cell.sv
// One track-point cell: holds a point origin, stores loads for its slot and tests queries.
module osdmp_cell #(
    parameter int INDEX   = 0,
    parameter int POINT_W = osdmp_pkg::POINT_W_DEF,
    parameter int POINT_H = osdmp_pkg::POINT_H_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  osdmp_pkg::item_t   in_item,
    input  osdmp_pkg::view_t   view,
    output logic               out_valid,
    output osdmp_pkg::item_t   out_item
);

    localparam int HALF_W = POINT_W / 2;
    localparam int HALF_H = POINT_H / 2;

    logic               valid_reg;
    osdmp_pkg::item_t   item_reg;
    osdmp_pkg::item_t   item_next;
    osdmp_pkg::coord_t  org_x_reg;
    osdmp_pkg::coord_t  org_y_reg;
    osdmp_pkg::coord_t  org_x_next;
    osdmp_pkg::coord_t  org_y_next;
    logic               load;
    logic               active;
    logic               hit;

    always_comb
    begin
        load = in_valid && !in_item.req
            && (osdmp_pkg::cnt_t'(in_item.slot) == osdmp_pkg::cnt_t'(INDEX));
        active = osdmp_pkg::cnt_t'(INDEX) < view.n_active;
        hit = active
            && osdmp_pkg::covers(in_item.x, osdmp_pkg::clamp(org_x_reg, view.pt_lim_x),
                                 osdmp_pkg::span_t'(POINT_W), view.canvas_w)
            && osdmp_pkg::covers(in_item.y, osdmp_pkg::clamp(org_y_reg, view.pt_lim_y),
                                 osdmp_pkg::span_t'(POINT_H), view.canvas_h);

        org_x_next = org_x_reg;
        org_y_next = org_y_reg;
        if (load)
        begin
            org_x_next = (in_item.x > osdmp_pkg::coord_t'(HALF_W))
                       ? in_item.x - osdmp_pkg::coord_t'(HALF_W) : '0;
            org_y_next = (in_item.y > osdmp_pkg::coord_t'(HALF_H))
                       ? in_item.y - osdmp_pkg::coord_t'(HALF_H) : '0;
        end

        item_next = in_item;
        if (in_item.req && !in_item.mhit && hit)
        begin
            item_next.color = osdmp_pkg::COLOR_GREEN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            org_x_reg <= '0;
            org_y_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
            org_x_reg <= org_x_next;
            org_y_reg <= org_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

>>> hdl/osd_marker_and_points_overlay_top.sv
// Top level of the overlay colour lookup: register port, entry stage, cell chain and output.
//
//  port group   | dir | contents
//  s_axis_*     | in  | request words: tuser = req_type, tdata = slot, x, y
//  m_axis_*     | out | one colour word per pixel query
//  APB p*       | in  | six configuration registers at byte addresses 0 to 20
//
// A word passes the entry stage, each cell in turn and then the output register; one
// word is accepted per cycle while the output is not held. Loads travel the same chain
// and give no result. Reset loads the register defaults and clears every stored point.
// When the output word is held, the whole chain stalls with it.
module osd_marker_and_points_overlay_top #(
    parameter int MAX_POINTS = osdmp_pkg::MAX_POINTS_DEF,
    parameter int MARKER_W   = osdmp_pkg::MARKER_W_DEF,
    parameter int MARKER_H   = osdmp_pkg::MARKER_H_DEF,
    parameter int POINT_W    = osdmp_pkg::POINT_W_DEF,
    parameter int POINT_H    = osdmp_pkg::POINT_H_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // point_slot[2:0], x_coord[14:3], y_coord[26:15], zero padding above
    input  logic [osdmp_pkg::S_DATA_BITS-1:0]    s_axis_tdata,
    // req_type[0]
    input  logic [0:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // color_index[3:0], zero padding above
    output logic [osdmp_pkg::M_DATA_BITS-1:0]    m_axis_tdata,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [osdmp_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [osdmp_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [osdmp_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                 pready
);

    localparam int CB = osdmp_pkg::COORD_BITS;
    localparam int SB = osdmp_pkg::SLOT_BITS;

    osdmp_pkg::coord_t  canvas_w_reg;
    osdmp_pkg::coord_t  canvas_h_reg;
    osdmp_pkg::coord_t  marker_x_reg;
    osdmp_pkg::coord_t  marker_y_reg;
    osdmp_pkg::color_t  marker_col_reg;
    osdmp_pkg::color_t  point_count_reg;
    osdmp_pkg::view_t   view_reg;
    osdmp_pkg::view_t   view_next;
    osdmp_pkg::reg_idx_t reg_idx;
    osdmp_pkg::coord_t  mk_lim_x;
    osdmp_pkg::coord_t  mk_lim_y;
    logic               cfg_wr;
    logic               en;
    osdmp_pkg::item_t   s_item;
    logic               chain_valid [0:MAX_POINTS];
    osdmp_pkg::item_t   chain_item  [0:MAX_POINTS];
    logic               out_valid_reg;
    osdmp_pkg::color_t  out_color_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = osdmp_pkg::reg_idx_t'(paddr[osdmp_pkg::ADDR_BITS-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_w_reg    <= osdmp_pkg::CANVAS_W_RESET;
            canvas_h_reg    <= osdmp_pkg::CANVAS_H_RESET;
            marker_x_reg    <= '0;
            marker_y_reg    <= '0;
            marker_col_reg  <= osdmp_pkg::COLOR_RED;
            point_count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                osdmp_pkg::REG_CANVAS_W:    canvas_w_reg    <= pwdata[CB-1:0];
                osdmp_pkg::REG_CANVAS_H:    canvas_h_reg    <= pwdata[CB-1:0];
                osdmp_pkg::REG_MARKER_X:    marker_x_reg    <= pwdata[CB-1:0];
                osdmp_pkg::REG_MARKER_Y:    marker_y_reg    <= pwdata[CB-1:0];
                osdmp_pkg::REG_MARKER_COL:  marker_col_reg  <= pwdata[osdmp_pkg::COLOR_BITS-1:0];
                osdmp_pkg::REG_POINT_COUNT: point_count_reg <= pwdata[osdmp_pkg::COLOR_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            osdmp_pkg::REG_CANVAS_W:    prdata = osdmp_pkg::APB_DATA_BITS'(canvas_w_reg);
            osdmp_pkg::REG_CANVAS_H:    prdata = osdmp_pkg::APB_DATA_BITS'(canvas_h_reg);
            osdmp_pkg::REG_MARKER_X:    prdata = osdmp_pkg::APB_DATA_BITS'(marker_x_reg);
            osdmp_pkg::REG_MARKER_Y:    prdata = osdmp_pkg::APB_DATA_BITS'(marker_y_reg);
            osdmp_pkg::REG_MARKER_COL:  prdata = osdmp_pkg::APB_DATA_BITS'(marker_col_reg);
            osdmp_pkg::REG_POINT_COUNT: prdata = osdmp_pkg::APB_DATA_BITS'(point_count_reg);
            default:                    prdata = '0;
        endcase
    end

    always_comb
    begin
        mk_lim_x = osdmp_pkg::place_lim(canvas_w_reg, osdmp_pkg::span_t'(MARKER_W));
        mk_lim_y = osdmp_pkg::place_lim(canvas_h_reg, osdmp_pkg::span_t'(MARKER_H));
        view_next.canvas_w = canvas_w_reg;
        view_next.canvas_h = canvas_h_reg;
        view_next.mk_org_x = osdmp_pkg::clamp(marker_x_reg, mk_lim_x);
        view_next.mk_org_y = osdmp_pkg::clamp(marker_y_reg, mk_lim_y);
        view_next.mk_color = osdmp_pkg::fix_color(marker_col_reg);
        view_next.pt_lim_x = osdmp_pkg::place_lim(canvas_w_reg, osdmp_pkg::span_t'(POINT_W));
        view_next.pt_lim_y = osdmp_pkg::place_lim(canvas_h_reg, osdmp_pkg::span_t'(POINT_H));
        view_next.n_active = (osdmp_pkg::cnt_t'(point_count_reg) > osdmp_pkg::cnt_t'(MAX_POINTS))
                           ? osdmp_pkg::cnt_t'(MAX_POINTS)
                           : osdmp_pkg::cnt_t'(point_count_reg);
    end

    always_ff @(posedge clk)
    begin
        view_reg <= view_next;
    end

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_comb
    begin
        s_item.req   = s_axis_tuser[0];
        s_item.slot  = s_axis_tdata[SB-1:0];
        s_item.x     = s_axis_tdata[SB+CB-1:SB];
        s_item.y     = s_axis_tdata[SB+2*CB-1:SB+CB];
        s_item.mhit  = 1'b0;
        s_item.color = osdmp_pkg::COLOR_CLEAR;
    end

    osdmp_head #(
        .MARKER_W (MARKER_W),
        .MARKER_H (MARKER_H)
    ) u_head (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_item   (s_item),
        .view      (view_reg),
        .out_valid (chain_valid[0]),
        .out_item  (chain_item[0])
    );

    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        osdmp_cell #(
            .INDEX   (i),
            .POINT_W (POINT_W),
            .POINT_H (POINT_H)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_item   (chain_item[i]),
            .view      (view_reg),
            .out_valid (chain_valid[i+1]),
            .out_item  (chain_item[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= chain_valid[MAX_POINTS] && chain_item[MAX_POINTS].req;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_color_reg <= chain_item[MAX_POINTS].color;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = osdmp_pkg::M_DATA_BITS'(out_color_reg);

`ifndef ASSERT_OFF
    a_out_color_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_color_reg == osdmp_pkg::COLOR_RED
                        || out_color_reg == osdmp_pkg::COLOR_GREEN
                        || out_color_reg == osdmp_pkg::COLOR_WHITE
                        || out_color_reg == osdmp_pkg::COLOR_CLEAR))
        else $error("overlay result is not a legal palette index");

    a_no_marker_colour: assert property (@(posedge clk) disable iff (!rst_n)
        (chain_valid[MAX_POINTS] && chain_item[MAX_POINTS].req && !chain_item[MAX_POINTS].mhit)
        |-> (chain_item[MAX_POINTS].color == osdmp_pkg::COLOR_GREEN
          || chain_item[MAX_POINTS].color == osdmp_pkg::COLOR_CLEAR))
        else $error("pixel outside the marker carries a marker colour");

    a_chain_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(chain_valid[MAX_POINTS]))
        else $error("cell chain moved during an output stall");
`endif

endmodule
